/* hw/rtl/bsrc_pkg.sv */
// Shared types and codes for the banker's safety and request checker.
package bsrc_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_TOTALS = 3'd0,
        OP_LOAD_MAX    = 3'd1,
        OP_LOAD_ALLOC  = 3'd2,
        OP_CHECK_SAFE  = 3'd3,
        OP_REQUEST     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_LOAD_DONE = 3'd0,
        ST_SAFE      = 3'd1,
        ST_UNSAFE    = 3'd2,
        ST_EXCEEDS   = 3'd3,
        ST_WAIT      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_RESULT
    } state_t;

    localparam logic [0:0] CFG_PROCS = 1'b0;
    localparam logic [0:0] CFG_KINDS = 1'b1;

endpackage

/* hw/rtl/bsrc_lane.sv */
// One process lane: compares a need row against work, per kind.
module bsrc_lane #(
    parameter int MAX_KINDS = 4,
    parameter int VAL_BITS  = 12
) (
    input  logic signed [MAX_KINDS-1:0][VAL_BITS-1:0] need,
    input  logic signed [MAX_KINDS-1:0][VAL_BITS-1:0] work,
    input  logic        [MAX_KINDS-1:0]               kind_en,
    input  logic                                      active,
    output logic                                      fits
);
    // fold the per-kind compares, two's complement on both sides
    always_comb
    begin
        fits = active;
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            if (kind_en[k] && ($signed(work[k]) < $signed(need[k])))
            begin
                fits = 1'b0;
            end
        end
    end
endmodule

/* hw/rtl/bsrc_pick.sv */
// Merge stage: pick the lowest-numbered lane that fits.
module bsrc_pick #(
    parameter int MAX_PROCS = 8,
    parameter int PW        = 3
) (
    input  logic [MAX_PROCS-1:0] fits,
    output logic                 found,
    output logic [PW-1:0]        idx
);
    // priority search, lowest first
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--)
        begin
            if (fits[i])
            begin
                found = 1'b1;
                idx   = PW'(i);
            end
        end
    end
endmodule

/* hw/rtl/bankers_safety_and_request_check.sv */
// Top level of the banker's safety and request checker.
// Usage: items enter on in_valid/in_stall with opcode, process and four amounts;
// results leave on out_valid/out_stall with status, seq_process and last. The
// configuration write channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// the process and kind counts; it is always ready. The user must write it only
// while idle; the block does not enforce this. A safety check finishes one
// process per cycle (all lanes compare need against work in parallel and the
// merge stage picks the lowest fitting one), then gives one result beat per
// cycle while out_stall is low. A request is checked in its decode cycle and,
// if unsafe, rolled back in the cycle that ends its safety pass, so it takes
// no longer than a safety check.
// The block takes one item at a time; in_stall is high while busy.
// Reset clears the max, alloc and need tables, available and work, and sets 8 processes and 4 kinds.
// While the receiver stalls, the current result beat is held unchanged and
// the sequencer waits.
module bankers_safety_and_request_check #(
    parameter int MAX_PROCS  = 8,
    parameter int MAX_KINDS  = 4,
    parameter int COUNT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic [2:0] process,
    input  logic [7:0] amount_0,
    input  logic [7:0] amount_1,
    input  logic [7:0] amount_2,
    input  logic [7:0] amount_3,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [2:0] seq_process,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_data
);
    import bsrc_pkg::*;

    localparam int VAL_BITS = COUNT_BITS + 4;
    localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;

    state_t state_reg, state_next;
    logic [3:0] procs_reg;
    logic [2:0] kinds_reg;
    cnt_t  max_reg   [MAX_PROCS][MAX_KINDS];
    cnt_t  alloc_reg [MAX_PROCS][MAX_KINDS];
    val_t  need_reg  [MAX_PROCS][MAX_KINDS];
    val_t  avail_reg [MAX_KINDS];
    val_t  work_reg  [MAX_KINDS];
    logic [MAX_PROCS-1:0] fin_reg;
    logic [PW-1:0] seq_reg [MAX_PROCS];
    logic [CW-1:0] count_reg, emit_reg;
    logic is_req_reg;
    logic [PW-1:0] rproc_reg;
    cnt_t amt_reg [MAX_KINDS];
    logic [2:0] status_reg;
    logic [2:0] op_reg;
    logic [2:0] pin_reg;

    // effective counts, saturated
    logic [CW-1:0] np;
    logic [MAX_KINDS-1:0] kind_en;
    always_comb
    begin
        if (procs_reg == 4'd0)
            np = CW'(1);
        else if (32'(procs_reg) > MAX_PROCS)
            np = CW'(MAX_PROCS);
        else
            np = CW'(procs_reg);
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            kind_en[k] = (k == 0) || (32'(kinds_reg) > k);
        end
    end

    // input amounts, masked and extended
    cnt_t amt_in [MAX_KINDS];
    always_comb
    begin
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            case (k)
                0: amt_in[k] = cnt_t'(amount_0);
                1: amt_in[k] = cnt_t'(amount_1);
                2: amt_in[k] = cnt_t'(amount_2);
                3: amt_in[k] = cnt_t'(amount_3);
                default: amt_in[k] = '0;
            endcase
        end
    end

    // lanes and merge stage
    logic [MAX_PROCS-1:0] fits;
    logic found;
    logic [PW-1:0] pick;
    logic signed [MAX_KINDS-1:0][VAL_BITS-1:0] work_pk;
    always_comb
    begin
        for (int k = 0; k < MAX_KINDS; k++)
            work_pk[k] = work_reg[k];
    end
    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_lane
        logic signed [MAX_KINDS-1:0][VAL_BITS-1:0] need_pk;
        always_comb
        begin
            for (int k = 0; k < MAX_KINDS; k++)
                need_pk[k] = need_reg[i][k];
        end
        bsrc_lane #(.MAX_KINDS(MAX_KINDS), .VAL_BITS(VAL_BITS)) u_lane (
            .need    (need_pk),
            .work    (work_pk),
            .kind_en (kind_en),
            .active  (!fin_reg[i] && (32'(i) < 32'(np))),
            .fits    (fits[i])
        );
    end
    bsrc_pick #(.MAX_PROCS(MAX_PROCS), .PW(PW)) u_pick (
        .fits  (fits),
        .found (found),
        .idx   (pick)
    );

    // request check: the lowest failing kind sets the status, EXCEEDS ahead of WAIT
    logic [2:0] req_status;
    logic       req_ok;
    always_comb
    begin
        req_ok = 1'b1;
        req_status = ST_UNSAFE;
        for (int k = MAX_KINDS - 1; k >= 0; k--)
        begin
            if (kind_en[k])
            begin
                if ($signed({1'b0, amt_reg[k]}) > need_reg[rproc_reg][k])
                begin
                    req_ok = 1'b0;
                    req_status = ST_EXCEEDS;
                end
                else if ($signed({1'b0, amt_reg[k]}) > avail_reg[k])
                begin
                    req_ok = 1'b0;
                    req_status = ST_WAIT;
                end
            end
        end
    end

    logic accept;
    logic out_fire;
    logic scan_done;
    assign accept    = in_valid && !in_stall;
    assign out_fire  = out_valid && !out_stall;
    assign scan_done = !found || (count_reg == np);
    assign cfg_ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = (count_reg == np) ? S_EMIT : S_RESULT;
            end
            S_EMIT:
            begin
                if (out_fire && (emit_reg + CW'(1) == np))
                    state_next = S_IDLE;
            end
            S_RESULT:
            begin
                if (out_valid && out_fire)
                    state_next = S_IDLE;
                else if (!out_valid)
                    state_next = (op_reg == OP_CHECK_SAFE ||
                                  (op_reg == OP_REQUEST
                                   && 32'(pin_reg) < 32'(np) && req_ok))
                                 ? S_SCAN : S_RESULT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    logic result_ready_reg;
    always_comb
    begin
        in_stall    = (state_reg != S_IDLE);
        out_valid   = 1'b0;
        status      = ST_LOAD_DONE;
        seq_process = '0;
        last        = 1'b1;
        unique case (state_reg)
            S_EMIT:
            begin
                out_valid   = 1'b1;
                status      = ST_SAFE;
                seq_process = 3'(seq_reg[emit_reg[PW-1:0]]);
                last        = (emit_reg + CW'(1) == np);
            end
            S_RESULT:
            begin
                out_valid = result_ready_reg;
                status    = status_reg;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            procs_reg        <= 4'd8;
            kinds_reg        <= 3'd4;
            result_ready_reg <= 1'b0;
            fin_reg          <= '0;
            count_reg        <= '0;
            emit_reg         <= '0;
            is_req_reg       <= 1'b0;
            op_reg           <= '0;
            status_reg       <= '0;
            for (int i = 0; i < MAX_PROCS; i++)
                for (int k = 0; k < MAX_KINDS; k++)
                begin
                    max_reg[i][k]   <= '0;
                    alloc_reg[i][k] <= '0;
                    need_reg[i][k]  <= '0;
                end
            for (int k = 0; k < MAX_KINDS; k++)
            begin
                avail_reg[k] <= '0;
                work_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROCS: procs_reg <= cfg_data;
                    CFG_KINDS: kinds_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    result_ready_reg <= 1'b0;
                    emit_reg <= '0;
                    if (accept)
                    begin
                        op_reg  <= opcode;
                        pin_reg <= process;
                        rproc_reg <= PW'(process);
                        for (int k = 0; k < MAX_KINDS; k++)
                            amt_reg[k] <= amt_in[k];
                    end
                end
                S_RESULT:
                begin
                    if (!result_ready_reg)
                    begin
                        // decode the held item
                        case (op_reg)
                            OP_LOAD_TOTALS:
                            begin
                                result_ready_reg <= 1'b1;
                                is_req_reg <= 1'b0;
                                status_reg <= ST_LOAD_DONE;
                                for (int i = 0; i < MAX_PROCS; i++)
                                    for (int k = 0; k < MAX_KINDS; k++)
                                    begin
                                        max_reg[i][k]   <= '0;
                                        alloc_reg[i][k] <= '0;
                                        need_reg[i][k]  <= '0;
                                    end
                                for (int k = 0; k < MAX_KINDS; k++)
                                    if (kind_en[k])
                                        avail_reg[k] <= val_t'(amt_reg[k]);
                            end
                            OP_LOAD_MAX:
                            begin
                                result_ready_reg <= 1'b1;
                                is_req_reg <= 1'b0;
                                status_reg <= ST_LOAD_DONE;
                                if (32'(pin_reg) < 32'(np))
                                    for (int k = 0; k < MAX_KINDS; k++)
                                        if (kind_en[k])
                                            max_reg[rproc_reg][k] <= amt_reg[k];
                            end
                            OP_LOAD_ALLOC:
                            begin
                                result_ready_reg <= 1'b1;
                                is_req_reg <= 1'b0;
                                status_reg <= ST_LOAD_DONE;
                                if (32'(pin_reg) < 32'(np))
                                    for (int k = 0; k < MAX_KINDS; k++)
                                        if (kind_en[k])
                                        begin
                                            alloc_reg[rproc_reg][k] <= amt_reg[k];
                                            need_reg[rproc_reg][k] <=
                                                val_t'(max_reg[rproc_reg][k])
                                                - val_t'(amt_reg[k]);
                                            avail_reg[k] <= avail_reg[k]
                                                - val_t'(amt_reg[k]);
                                        end
                            end
                            OP_CHECK_SAFE:
                            begin
                                is_req_reg <= 1'b0;
                                status_reg <= ST_UNSAFE;
                                fin_reg   <= '0;
                                count_reg <= '0;
                                for (int k = 0; k < MAX_KINDS; k++)
                                    work_reg[k] <= avail_reg[k];
                            end
                            OP_REQUEST:
                            begin
                                if (32'(pin_reg) >= 32'(np))
                                begin
                                    result_ready_reg <= 1'b1;
                                    is_req_reg <= 1'b0;
                                    status_reg <= ST_UNSAFE;
                                end
                                else if (!req_ok)
                                begin
                                    result_ready_reg <= 1'b1;
                                    is_req_reg <= 1'b0;
                                    status_reg <= req_status;
                                end
                                else
                                begin
                                    // tentative grant, then a safety pass
                                    status_reg <= ST_UNSAFE;
                                    is_req_reg <= 1'b1;
                                    fin_reg   <= '0;
                                    count_reg <= '0;
                                    for (int k = 0; k < MAX_KINDS; k++)
                                        if (kind_en[k])
                                        begin
                                            avail_reg[k] <= avail_reg[k]
                                                - val_t'(amt_reg[k]);
                                            work_reg[k] <= avail_reg[k]
                                                - val_t'(amt_reg[k]);
                                            alloc_reg[rproc_reg][k] <=
                                                alloc_reg[rproc_reg][k] + amt_reg[k];
                                            need_reg[rproc_reg][k] <=
                                                need_reg[rproc_reg][k]
                                                - val_t'(amt_reg[k]);
                                        end
                                        else
                                            work_reg[k] <= avail_reg[k];
                                end
                            end
                            default:
                            begin
                                result_ready_reg <= 1'b1;
                                is_req_reg <= 1'b0;
                                status_reg <= ST_UNSAFE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (!scan_done)
                    begin
                        fin_reg[pick] <= 1'b1;
                        seq_reg[count_reg[PW-1:0]] <= pick;
                        count_reg <= count_reg + CW'(1);
                        for (int k = 0; k < MAX_KINDS; k++)
                            if (kind_en[k])
                                work_reg[k] <= work_reg[k] + val_t'(alloc_reg[pick][k]);
                    end
                    else if (count_reg != np)
                    begin
                        // unsafe: roll back a tentative grant
                        result_ready_reg <= 1'b1;
                        status_reg <= ST_UNSAFE;
                        op_reg <= OP_CHECK_SAFE;
                        if (is_req_reg)
                            for (int k = 0; k < MAX_KINDS; k++)
                                if (kind_en[k])
                                begin
                                    avail_reg[k] <= avail_reg[k] + val_t'(amt_reg[k]);
                                    alloc_reg[rproc_reg][k] <=
                                        alloc_reg[rproc_reg][k] - amt_reg[k];
                                    need_reg[rproc_reg][k] <=
                                        need_reg[rproc_reg][k] + val_t'(amt_reg[k]);
                                end
                    end
                end
                S_EMIT:
                begin
                    if (out_fire)
                        emit_reg <= emit_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end
endmodule
